// ===== hw/rtl/krd_pkg.sv =====
// ----------------------------------------------------------------------------
// krd_pkg
// Shared types, constants and the CRC-16/X-25 byte update for the key report
// packet deframer.
// ----------------------------------------------------------------------------
package krd_pkg;

    localparam logic [7:0]  TYPE_BYTE   = 8'h80;
    localparam logic [7:0]  LENGTH_BYTE = 8'h01;
    localparam logic [15:0] CRC_START   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    // Byte position within a packet.
    localparam logic [2:0] POS_HUNT   = 3'd0;
    localparam logic [2:0] POS_LEN    = 3'd1;
    localparam logic [2:0] POS_KEY    = 3'd2;
    localparam logic [2:0] POS_CHK_LO = 3'd3;
    localparam logic [2:0] POS_CHK_HI = 3'd4;

    typedef struct packed {
        logic       emit;
        logic [7:0] key_code;
        logic       check_status;
    } t_result;

    // Reflected CRC update over one byte, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/krd_parser.sv =====
// ----------------------------------------------------------------------------
// krd_parser
// Packet position tracking and running CRC. Presents the result that the
// current byte would produce; state advances when the byte is consumed.
// ----------------------------------------------------------------------------
module krd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output krd_pkg::t_result o_res
);

    logic [2:0]  r_pos;
    logic [15:0] r_crc;
    logic [7:0]  r_key;
    logic [7:0]  r_chk_lo;

    logic [2:0]  n_pos;
    logic [15:0] n_crc;
    logic [7:0]  n_key;
    logic [7:0]  n_chk_lo;
    logic [15:0] crc_upd;

    assign crc_upd = krd_pkg::crc_feed(r_crc, i_byte);

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_key    = r_key;
        n_chk_lo = r_chk_lo;
        case (r_pos)
            krd_pkg::POS_LEN: begin
                // Stay here, dropping bytes, until the length byte shows up.
                if (i_byte == krd_pkg::LENGTH_BYTE) begin
                    n_crc = crc_upd;
                    n_pos = krd_pkg::POS_KEY;
                end
            end
            krd_pkg::POS_KEY: begin
                n_key = i_byte;
                n_crc = crc_upd;
                n_pos = krd_pkg::POS_CHK_LO;
            end
            krd_pkg::POS_CHK_LO: begin
                n_chk_lo = i_byte;
                n_pos    = krd_pkg::POS_CHK_HI;
            end
            krd_pkg::POS_CHK_HI: begin
                n_pos = krd_pkg::POS_HUNT;
                n_crc = krd_pkg::CRC_START;
            end
            default: begin
                if (i_byte == krd_pkg::TYPE_BYTE) begin
                    n_crc = krd_pkg::crc_feed(krd_pkg::CRC_START, i_byte);
                    n_pos = krd_pkg::POS_LEN;
                end else begin
                    n_crc = krd_pkg::CRC_START;
                    n_pos = krd_pkg::POS_HUNT;
                end
            end
        endcase
    end

    always_comb begin
        o_res.emit         = (r_pos == krd_pkg::POS_CHK_HI);
        o_res.key_code     = r_key;
        o_res.check_status = ({i_byte, r_chk_lo} != ~r_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= krd_pkg::POS_HUNT;
            r_crc    <= krd_pkg::CRC_START;
            r_key    <= 8'h00;
            r_chk_lo <= 8'h00;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_key    <= n_key;
            r_chk_lo <= n_chk_lo;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= krd_pkg::POS_CHK_HI)
        else $error("packet position out of range");

    a_type_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_pos == krd_pkg::POS_HUNT && i_byte == krd_pkg::TYPE_BYTE
        |=> r_pos == krd_pkg::POS_LEN)
        else $error("type byte did not start a packet");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.emit |=> r_crc == krd_pkg::CRC_START && r_pos == krd_pkg::POS_HUNT)
        else $error("CRC not restarted after packet end");

endmodule

// ===== hw/rtl/krd_out_stage.sv =====
// ----------------------------------------------------------------------------
// krd_out_stage
// Result register toward the output channel. Holds a result until it is
// taken and reports whether a new one can be loaded this cycle.
// ----------------------------------------------------------------------------
module krd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  krd_pkg::t_result i_res,
    input  logic             i_out_stall,
    output logic             o_free,
    output logic             o_out_valid,
    output logic [7:0]       o_key_code,
    output logic             o_check_status
);

    logic       r_valid;
    logic [7:0] r_key;
    logic       r_status;

    assign o_free         = !r_valid || !i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_key_code     = r_key;
    assign o_check_status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_key    <= i_res.key_code;
            r_status <= i_res.check_status;
        end
    end

endmodule

// ===== hw/rtl/key_report_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// key_report_packet_deframer_top
// Finds five-byte key report packets in a received byte stream and reports
// the key code with a CRC-16/X-25 pass/fail status.
// ----------------------------------------------------------------------------
// Output path: the last byte of a packet waits in the input register, and the
// result register loads its result when that byte is consumed.
// Throughput: one byte per cycle; the input stalls only while a result waits
// in the result register and the byte in the input register would make another.
// Reset (synchronous, active low) empties both registers and returns the
// parser to hunting for a type byte with the CRC at its start value.
module key_report_packet_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_key_code,
    output logic       o_check_status
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    krd_pkg::t_result res;
    logic             out_free;
    logic             fire;
    logic             in_take;

    // A byte that makes no result never needs the result register.
    assign fire       = r_in_valid && (!res.emit || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    krd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    krd_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire && res.emit),
        .i_res          (res),
        .i_out_stall    (i_out_stall),
        .o_free         (out_free),
        .o_out_valid    (o_out_valid),
        .o_key_code     (o_key_code),
        .o_check_status (o_check_status)
    );

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in_byte))
        else $error("buffered byte lost while stalled");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.emit |-> out_free)
        else $error("result loaded over a waiting result");

endmodule
